[rtl/core/token_record_extractor_defines.svh]
// ----------------------------------------------------------------------------
// token record extractor assertion macros
// shared concurrent check forms, clocked on clk and quiet during rst
// ----------------------------------------------------------------------------
`ifndef TOKEN_RECORD_EXTRACTOR_DEFINES_SVH
`define TOKEN_RECORD_EXTRACTOR_DEFINES_SVH

// same-cycle implication
`define TRE_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TRE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tre_pkg.sv]
// ----------------------------------------------------------------------------
// tre_pkg
// types and constants of the token record extractor
// ----------------------------------------------------------------------------
package tre_pkg;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_RECORD,
    PH_VALUE
  } tre_phase_t;

  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_MARKER = 2'd2;

  localparam logic [2:0] MARKER_LEN  = 3'd5;
  localparam int         LEN_LO_POS  = 8;
  localparam int         LEN_HI_POS  = 9;
  localparam logic [7:0] CHAR_T      = 8'h54;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       incomplete;
  } tre_res_t;

  // results caused by one input byte
  typedef struct packed {
    logic     two;
    tre_res_t r0;
    tre_res_t r1;
  } tre_entry_t;

  function automatic logic [7:0] marker_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h54;  // T
      3'd1:    b = 8'h4f;  // O
      3'd2:    b = 8'h4b;  // K
      3'd3:    b = 8'h4e;  // N
      default: b = 8'h01;
    endcase
    return b;
  endfunction

endpackage

[rtl/core/tre_ifs.sv]
// ----------------------------------------------------------------------------
// tre stream interfaces
// byte input channel and result output channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface tre_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_buffer;

  modport source (output valid, output in_byte, output end_of_buffer, input ready);
  modport sink (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface tre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       incomplete;
  logic       last;

  modport source (output valid, output out_byte, output kind, output incomplete,
                  output last, input ready);
  modport sink (input valid, input out_byte, input kind, input incomplete,
                input last, output ready);
endinterface

[rtl/core/token_record_extractor.sv]
// ----------------------------------------------------------------------------
// token_record_extractor
// scans a token store for TOKN records and streams out key and value text
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle; its state update is done in the same
// cycle and its one or two result words go into a two-entry result queue, so
// the input keeps flowing while the output side stalls. A byte that yields
// two words (a character plus a record marker) holds the output port until
// both are taken; input stops only when the queue holds two bytes' worth of results.
module token_record_extractor
  import tre_pkg::*;
#(
  parameter int KEY_START = 20,
  parameter int KEY_LEN   = 16
) (
  input  logic  clk,
  input  logic  rst,
  tre_in_if.sink    tokens,
  tre_out_if.source records
);

`include "token_record_extractor_defines.svh"

  localparam int POS_W = $clog2(KEY_START + KEY_LEN);
  localparam logic [POS_W-1:0] KEY_FIRST = POS_W'(KEY_START);
  localparam logic [POS_W-1:0] KEY_LAST  = POS_W'(KEY_START + KEY_LEN - 1);
  localparam logic [POS_W-1:0] POS_LO    = POS_W'(LEN_LO_POS);
  localparam logic [POS_W-1:0] POS_HI    = POS_W'(LEN_HI_POS);
  localparam logic [POS_W-1:0] POS_BODY  = POS_W'(MARKER_LEN);

  // scan state
  tre_phase_t       phase, phase_next;
  logic [2:0]       marker_progress, marker_progress_next;
  logic [POS_W-1:0] record_position, record_position_next;
  logic [15:0]      value_length, value_length_next;
  logic [15:0]      value_remaining, value_remaining_next;
  logic             key_terminated, key_terminated_next;
  logic             value_terminated, value_terminated_next;

  // per-byte events
  logic       char_emit;
  logic [1:0] char_kind;
  logic       done_hit;
  logic       open_at_end;
  tre_entry_t new_entry;
  logic       new_any;

  // result queue
  tre_entry_t entries [2];
  logic       wr_ptr, rd_ptr, sub;
  logic [1:0] cnt;
  tre_entry_t head;
  tre_res_t   cur;
  logic       accept, push, pop, out_last;

  assign tokens.ready = (cnt != 2'd2);
  assign accept       = tokens.valid && tokens.ready;

  // next-state logic
  always_comb begin
    logic [7:0]  b;
    logic [2:0]  mp;
    logic [15:0] vrem_dec;
    b        = tokens.in_byte;
    mp       = (marker_progress > 3'd4) ? 3'd0 : marker_progress;
    vrem_dec = value_remaining - 16'd1;

    phase_next            = phase;
    marker_progress_next  = marker_progress;
    record_position_next  = record_position;
    value_length_next     = value_length;
    value_remaining_next  = value_remaining;
    key_terminated_next   = key_terminated;
    value_terminated_next = value_terminated;
    char_emit             = 1'b0;
    char_kind             = KIND_KEY;
    done_hit              = 1'b0;

    unique case (phase)
      PH_SEARCH: begin
        if (b == marker_byte(mp)) begin
          marker_progress_next = mp + 3'd1;
        end else begin
          marker_progress_next = (b == CHAR_T) ? 3'd1 : 3'd0;
        end
        if (marker_progress_next == MARKER_LEN) begin
          marker_progress_next  = 3'd0;
          phase_next            = PH_RECORD;
          record_position_next  = POS_BODY;
          value_length_next     = 16'd0;
          value_remaining_next  = 16'd0;
          key_terminated_next   = 1'b0;
          value_terminated_next = 1'b0;
        end
      end
      PH_VALUE: begin
        if (!value_terminated) begin
          if (b == 8'd0) begin
            value_terminated_next = 1'b1;
          end else begin
            char_emit = 1'b1;
            char_kind = KIND_VALUE;
          end
        end
        value_remaining_next = vrem_dec;
        if (vrem_dec == 16'd0) begin
          done_hit   = 1'b1;
          phase_next = PH_SEARCH;
        end
      end
      PH_RECORD: begin
        if (record_position == POS_LO) begin
          value_length_next = {value_length[15:8], b};
        end else if (record_position == POS_HI) begin
          value_length_next = {b, value_length[7:0]};
        end
        if (record_position >= KEY_FIRST && record_position <= KEY_LAST
            && !key_terminated) begin
          if (b == 8'd0) begin
            key_terminated_next = 1'b1;
          end else begin
            char_emit = 1'b1;
            char_kind = KIND_KEY;
          end
        end
        if (record_position >= KEY_LAST) begin
          if (value_length_next == 16'd0) begin
            done_hit   = 1'b1;
            phase_next = PH_SEARCH;
          end else begin
            phase_next           = PH_VALUE;
            value_remaining_next = value_length_next;
          end
        end else begin
          record_position_next = record_position + 1'b1;
        end
      end
      default: begin
        phase_next = PH_SEARCH;
      end
    endcase

    open_at_end = tokens.end_of_buffer && (phase_next != PH_SEARCH);

    // end of buffer drops everything back to the idle search
    if (tokens.end_of_buffer) begin
      phase_next            = PH_SEARCH;
      marker_progress_next  = 3'd0;
      record_position_next  = '0;
      value_length_next     = 16'd0;
      value_remaining_next  = 16'd0;
      key_terminated_next   = 1'b0;
      value_terminated_next = 1'b0;
    end
  end

  // result words for this byte
  always_comb begin
    tre_res_t ch, mk;
    logic     mk_valid;
    ch.data       = tokens.in_byte;
    ch.kind       = char_kind;
    ch.incomplete = 1'b0;
    mk.data       = 8'd0;
    mk.kind       = KIND_MARKER;
    mk.incomplete = open_at_end;
    mk_valid      = done_hit || open_at_end;

    new_any = char_emit || mk_valid;
    if (char_emit) begin
      new_entry.two = mk_valid;
      new_entry.r0  = ch;
      new_entry.r1  = mk;
    end else begin
      new_entry.two = 1'b0;
      new_entry.r0  = mk;
      new_entry.r1  = mk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_SEARCH;
      marker_progress  <= 3'd0;
      record_position  <= '0;
      value_length     <= 16'd0;
      value_remaining  <= 16'd0;
      key_terminated   <= 1'b0;
      value_terminated <= 1'b0;
    end else if (accept) begin
      phase            <= phase_next;
      marker_progress  <= marker_progress_next;
      record_position  <= record_position_next;
      value_length     <= value_length_next;
      value_remaining  <= value_remaining_next;
      key_terminated   <= key_terminated_next;
      value_terminated <= value_terminated_next;
    end
  end

  // output side
  assign head     = entries[rd_ptr];
  assign cur      = sub ? head.r1 : head.r0;
  assign out_last = sub || !head.two;

  assign records.valid      = (cnt != 2'd0);
  assign records.out_byte   = cur.data;
  assign records.kind       = cur.kind;
  assign records.incomplete = cur.incomplete;
  assign records.last       = out_last;

  assign push = accept && new_any;
  assign pop  = records.valid && records.ready && out_last;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      sub    <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (records.valid && records.ready) begin
        sub <= !out_last;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  `TRE_ASSERT_IMPL(a_queue_bound, 1'b1, cnt <= 2'd2, "result queue overfilled")
  `TRE_ASSERT_IMPL(a_marker_zero, records.valid && records.kind == KIND_MARKER,
    records.out_byte == 8'd0, "marker word carries a character")
  `TRE_ASSERT_IMPL(a_incomplete_marker, records.valid && records.incomplete,
    records.kind == KIND_MARKER && records.last, "incomplete flag off a final marker")
  `TRE_ASSERT_IMPL(a_value_left, phase == PH_VALUE, value_remaining != 16'd0,
    "value phase with nothing left")
  `TRE_ASSERT_NEXT(a_eob_reset, accept && tokens.end_of_buffer,
    phase == PH_SEARCH && marker_progress == 3'd0, "scan state kept past buffer end")

endmodule
